// ----- hw/rtl/periodic_event_slots_and_down_counters_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the periodic event slot and down-counter block
// Each macro checks an implication on the rising edge of clk. Checks are
// off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_EVENT_SLOTS_AND_DOWN_COUNTERS_ASSERT_SVH
`define PERIODIC_EVENT_SLOTS_AND_DOWN_COUNTERS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PESDC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pesdc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PESDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pesdc: next-cycle check failed");

`endif

// ----- hw/rtl/pesdc_pkg.sv -----
// ---------------------------------------------------------------------------
// pesdc_pkg
// Types, sizes and codes shared by the periodic event slot block.
// ---------------------------------------------------------------------------
package pesdc_pkg;

	localparam int EVENT_SLOTS   = 15;
	localparam int DOWN_COUNTERS = 15;

	localparam int SLOT_IW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
	localparam int CNT_IW  = (DOWN_COUNTERS > 1) ? $clog2(DOWN_COUNTERS) : 1;
	localparam int CNT_TW  = $clog2(DOWN_COUNTERS + 1);

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_REG_HND = 3'd1;
	localparam logic [2:0] OP_DEL_HND = 3'd2;
	localparam logic [2:0] OP_REG_CNT = 3'd3;
	localparam logic [2:0] OP_WR_CNT  = 3'd4;
	localparam logic [2:0] OP_RD_CNT  = 3'd5;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_FULL      = 2'd1;
	localparam logic [1:0] STS_NOT_FOUND = 2'd2;
	localparam logic [1:0] STS_DUPLICATE = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  handle;
		logic [31:0] interval;
		logic [15:0] counter_key;
		logic [31:0] counter_load;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        fired;
		logic [7:0]  fired_handle;
		logic [31:0] counter_value;
		logic        last;
	} res_t;

endpackage

// ----- hw/rtl/periodic_event_slots_and_down_counters.sv -----
// ---------------------------------------------------------------------------
// periodic_event_slots_and_down_counters
// Table of periodic event slots and table of down-counters behind one
// request channel and one result channel.
// ---------------------------------------------------------------------------
// A request is taken only while the block is idle (req_stall low) and is then
// worked through by a small sequencer that visits one table entry per cycle
// with one shared unit per table. A tick walks all EVENT_SLOTS slots and
// then every registered down-counter; register and delete handle walk all
// slots; counter requests walk the registered counters, except a register
// counter on a full table or any counter request on an empty table, which,
// like unused codes, go straight to the final result. Each fired slot gives
// one result (last marks the final one);
// a tick with no fired slot gives one empty result, every other request gives
// exactly one result. Results sit in an output register, so a new request is
// taken while the previous final result still waits; the walk pauses only when
// it has a result to hand over and the output register is stalled. Tables
// live in flip-flops; no clearing pass runs after reset.
// ---------------------------------------------------------------------------
module periodic_event_slots_and_down_counters (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  pesdc_pkg::req_t req,
	output logic            res_valid,
	input  logic            res_stall,
	output pesdc_pkg::res_t res
);
	import pesdc_pkg::*;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SLOT = 2'd1;
	localparam logic [1:0] ST_CNT  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic [SLOT_IW-1:0] SLOT_LAST = SLOT_IW'(EVENT_SLOTS - 1);

	logic [1:0] state_q;

	// captured request
	logic [2:0]  op_q;
	logic [7:0]  hnd_q;
	logic [31:0] ivl_q;
	logic [15:0] key_q;
	logic [31:0] load_q;

	// walk indexes and search results
	logic [SLOT_IW-1:0] idx_q;
	logic [CNT_IW-1:0]  cidx_q;
	logic               hit_q;
	logic               free_found_q;
	logic [SLOT_IW-1:0] free_idx_q;
	logic [CNT_IW-1:0]  match_idx_q;
	logic [31:0]        match_val_q;

	// fired slot held back until we know whether it is the last one
	logic       pend_valid_q;
	logic [7:0] pend_handle_q;

	// slot table
	logic [EVENT_SLOTS-1:0] slot_used_q;
	logic [7:0]             slot_handle_q [EVENT_SLOTS];
	logic [31:0]            slot_ivl_q    [EVENT_SLOTS];
	logic [31:0]            slot_cnt_q    [EVENT_SLOTS];

	// down-counter table
	logic [15:0]       cnt_key_q [DOWN_COUNTERS];
	logic [31:0]       cnt_val_q [DOWN_COUNTERS];
	logic [CNT_TW-1:0] cnt_total_q;

	// output register
	logic res_valid_q;
	res_t res_q;

	logic        accept;
	logic        out_free;
	logic        cur_used;
	logic [7:0]  cur_hnd;
	logic [31:0] cur_cnt;
	logic [31:0] cnt_inc;
	logic        fire;
	logic        hnd_hit;
	logic        slot_hold;
	logic        slot_go;
	logic        slot_emit;
	logic [15:0] cur_key;
	logic [31:0] cur_val;
	logic        key_hit;
	logic        cnt_last;
	logic        cnt_full;
	logic        fin_go;
	logic        res_load;
	res_t        fin_res;
	res_t        res_d;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !res_valid_q || !res_stall;

	// shared slot unit: one increment and the interval and handle compares per cycle
	assign cur_used = slot_used_q[idx_q];
	assign cur_hnd  = slot_handle_q[idx_q];
	assign cur_cnt  = slot_cnt_q[idx_q];
	assign cnt_inc  = cur_cnt + 32'd1;
	assign fire     = cur_used && (cnt_inc == slot_ivl_q[idx_q]);
	assign hnd_hit  = cur_used && (cur_hnd == hnd_q);

	// hold the slot walk when a second fire needs the busy output register
	assign slot_hold = (op_q == OP_TICK) && fire && pend_valid_q && !out_free;
	assign slot_go   = (state_q == ST_SLOT) && !slot_hold;
	assign slot_emit = (state_q == ST_SLOT) && (op_q == OP_TICK) && fire
		&& pend_valid_q && out_free;

	// shared counter unit: one key compare and one decrement per cycle
	assign cur_key  = cnt_key_q[cidx_q];
	assign cur_val  = cnt_val_q[cidx_q];
	assign key_hit  = (cur_key == key_q);
	assign cnt_last = ((CNT_TW'(cidx_q) + CNT_TW'(1)) == cnt_total_q);
	assign cnt_full = (cnt_total_q >= CNT_TW'(DOWN_COUNTERS));

	assign fin_go   = (state_q == ST_FIN) && out_free;
	assign res_load = slot_emit || fin_go;

	// final result of the request
	always_comb begin
		fin_res = '0;
		fin_res.last = 1'b1;
		case (op_q)
			OP_TICK: begin
				if (pend_valid_q) begin
					fin_res.fired        = 1'b1;
					fin_res.fired_handle = pend_handle_q;
				end
			end
			OP_REG_HND: begin
				if (!hit_q && !free_found_q) begin
					fin_res.status = STS_FULL;
				end
			end
			OP_DEL_HND: begin
				if (!hit_q) begin
					fin_res.status = STS_NOT_FOUND;
				end
			end
			OP_REG_CNT: begin
				if (cnt_full) begin
					fin_res.status = STS_FULL;
				end else if (hit_q) begin
					fin_res.status = STS_DUPLICATE;
				end
			end
			OP_WR_CNT: begin
				if (!hit_q) begin
					fin_res.status = STS_NOT_FOUND;
				end
			end
			OP_RD_CNT: begin
				if (hit_q) begin
					fin_res.counter_value = match_val_q;
				end else begin
					fin_res.status = STS_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_d = fin_res;
		if (slot_emit) begin
			res_d               = '0;
			res_d.status        = STS_OK;
			res_d.fired         = 1'b1;
			res_d.fired_handle  = pend_handle_q;
			res_d.last          = 1'b0;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			pend_valid_q <= 1'b0;
			slot_used_q  <= '0;
			cnt_total_q  <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						pend_valid_q <= 1'b0;
						case (req.operation)
							OP_TICK, OP_REG_HND, OP_DEL_HND: begin
								state_q <= ST_SLOT;
							end
							OP_REG_CNT, OP_WR_CNT, OP_RD_CNT: begin
								if (cnt_total_q == '0 ||
									(req.operation == OP_REG_CNT && cnt_full)) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_CNT;
								end
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SLOT: begin
					if (slot_go) begin
						case (op_q)
							OP_TICK: begin
								if (fire) begin
									pend_valid_q <= 1'b1;
								end
							end
							OP_REG_HND: begin
								if (hnd_hit) begin
									hit_q <= 1'b1;
								end
								if (!cur_used) begin
									free_found_q <= 1'b1;
								end
							end
							OP_DEL_HND: begin
								if (hnd_hit) begin
									hit_q            <= 1'b1;
									slot_used_q[idx_q] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
						if (idx_q == SLOT_LAST) begin
							if (op_q == OP_TICK && cnt_total_q != '0) begin
								state_q <= ST_CNT;
							end else begin
								state_q <= ST_FIN;
							end
						end
					end
				end
				ST_CNT: begin
					if (op_q != OP_TICK && key_hit) begin
						hit_q <= 1'b1;
					end
					if (cnt_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q      <= ST_IDLE;
						pend_valid_q <= 1'b0;
						if (op_q == OP_REG_HND && !hit_q && free_found_q) begin
							slot_used_q[free_idx_q] <= 1'b1;
						end
						if (op_q == OP_REG_CNT && !cnt_full && !hit_q) begin
							cnt_total_q <= cnt_total_q + CNT_TW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture, walk indexes and table payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.operation;
			hnd_q  <= req.handle;
			ivl_q  <= req.interval;
			key_q  <= req.counter_key;
			load_q <= req.counter_load;
			idx_q  <= '0;
			cidx_q <= '0;
		end

		if (slot_go) begin
			if (idx_q != SLOT_LAST) begin
				idx_q <= idx_q + SLOT_IW'(1);
			end
			// advance the count of a used slot, clear it when it fires
			if (op_q == OP_TICK && cur_used) begin
				slot_cnt_q[idx_q] <= fire ? 32'd0 : cnt_inc;
			end
			if (op_q == OP_TICK && fire) begin
				pend_handle_q <= cur_hnd;
			end
			if (op_q == OP_REG_HND && !cur_used && !free_found_q) begin
				free_idx_q <= idx_q;
			end
		end

		if (state_q == ST_CNT) begin
			cidx_q <= cidx_q + CNT_IW'(1);
			// drop every registered nonzero counter by one
			if (op_q == OP_TICK && cur_val != 32'd0) begin
				cnt_val_q[cidx_q] <= cur_val - 32'd1;
			end
			if (op_q != OP_TICK && key_hit && !hit_q) begin
				match_idx_q <= cidx_q;
				match_val_q <= cur_val;
			end
		end

		if (fin_go) begin
			if (op_q == OP_REG_HND && !hit_q && free_found_q) begin
				slot_handle_q[free_idx_q] <= hnd_q;
				slot_ivl_q[free_idx_q]    <= ivl_q;
				slot_cnt_q[free_idx_q]    <= 32'd0;
			end
			if (op_q == OP_REG_CNT && !cnt_full && !hit_q) begin
				cnt_key_q[cnt_total_q[CNT_IW-1:0]] <= key_q;
				cnt_val_q[cnt_total_q[CNT_IW-1:0]] <= 32'd0;
			end
			if (op_q == OP_WR_CNT && hit_q) begin
				cnt_val_q[match_idx_q] <= load_q;
			end
		end

		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`include "periodic_event_slots_and_down_counters_assert.svh"

	`PESDC_ASSERT_SAME(a_total_bound, 1'b1, cnt_total_q <= CNT_TW'(DOWN_COUNTERS))
	`PESDC_ASSERT_SAME(a_idle_no_pend, state_q == ST_IDLE, !pend_valid_q)
	`PESDC_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE)
	`PESDC_ASSERT_NEXT(a_fin_done, fin_go, state_q == ST_IDLE && res_valid_q && res_q.last)

endmodule
